[sv/tscs_pkg.sv]
// Shared types and constants for the time sync client sequencer.
package tscs_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_RETRY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_RETRY    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REFRESH       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REPLY_TIMEOUT = 3'd4;

  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_REPLY  = 2'd3;

  localparam logic [31:0] EPOCH_OFFSET = 32'd2208988800;
  localparam logic [2:0]  MODE_SERVER  = 3'h4;
  localparam logic [15:0] MSG_LEN      = 16'd48;
  localparam logic [15:0] SERVER_PORT  = 16'd123;

  typedef enum logic [3:0] {
    ST_INIT        = 4'd0,
    ST_LOOKUP      = 4'd1,
    ST_LOOKUP_WAIT = 4'd2,
    ST_LOOKUP_FAIL = 4'd3,
    ST_REQUEST     = 4'd4,
    ST_WAIT        = 4'd5,
    ST_TIMEOUT     = 4'd6,
    ST_SET_FAIL    = 4'd7,
    ST_SUCCESS     = 4'd8,
    ST_ERROR       = 4'd9
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        link_ready;
    logic        socket_ok;
    logic        lookup_immediate;
    logic        lookup_found;
    logic        from_server;
    logic [15:0] source_port;
    logic [15:0] datagram_length;
    logic [7:0]  first_byte;
    logic [7:0]  stratum;
    logic [31:0] server_seconds;
    logic        set_time_ok;
  } in_data_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        start_lookup;
    logic        send_request;
    logic        time_strobe;
    logic [31:0] unix_seconds;
    logic [3:0]  retry_count;
  } out_data_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [31:0] short_retry_ticks;
    logic [31:0] long_retry_ticks;
    logic [31:0] refresh_ticks;
    logic [31:0] reply_timeout_ticks;
  } cfg_regs_t;

endpackage

[sv/tscs_cfg.sv]
// Configuration register file for the time sync client sequencer.
module tscs_cfg
  import tscs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_regs_t           regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.retry_limit         <= 4'd5;
      regs_r.short_retry_ticks   <= 32'd2000;
      regs_r.long_retry_ticks    <= 32'd60000;
      regs_r.refresh_ticks       <= 32'd86400000;
      regs_r.reply_timeout_ticks <= 32'd2000;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_RETRY_LIMIT:   regs_r.retry_limit         <= wr_data[3:0];
        CFG_SHORT_RETRY:   regs_r.short_retry_ticks   <= wr_data;
        CFG_LONG_RETRY:    regs_r.long_retry_ticks    <= wr_data;
        CFG_REFRESH:       regs_r.refresh_ticks       <= wr_data;
        CFG_REPLY_TIMEOUT: regs_r.reply_timeout_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

[sv/tscs_core.sv]
// Sequencer state registers and the single-pass next-state and result logic.
module tscs_core
  import tscs_pkg::*;
#(
  parameter int TIMER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_data_t  item,
  input  cfg_regs_t cfg,
  output out_data_t result
);

  localparam logic [63:0] TimerMax = {64{1'b1}} >> (64 - TIMER_WIDTH);

  function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [31:0] v);
    logic [63:0] v64;
    v64 = 64'(v);
    return (v64 > TimerMax) ? TIMER_WIDTH'(TimerMax) : TIMER_WIDTH'(v64);
  endfunction

  status_t                status_r, status_nxt;
  logic [3:0]             quick_r, quick_nxt;
  logic [TIMER_WIDTH-1:0] retry_cnt_r, retry_cnt_nxt;
  logic [TIMER_WIDTH-1:0] tmo_cnt_r, tmo_cnt_nxt;
  logic                   sock_r, sock_nxt;

  logic                   arm_more;
  logic [3:0]             arm_quick;
  logic [TIMER_WIDTH-1:0] arm_retry;
  logic                   reply_ok;

  // Retry arming: short period while quick retries remain, long period after.
  assign arm_more  = quick_r < cfg.retry_limit;
  assign arm_quick = arm_more ? quick_r + 4'd1 : quick_r;
  assign arm_retry = arm_more ? timer_load(cfg.short_retry_ticks)
                              : timer_load(cfg.long_retry_ticks);

  assign reply_ok = sock_r && item.from_server &&
                    (item.source_port == SERVER_PORT) &&
                    (item.datagram_length == MSG_LEN) &&
                    (item.first_byte[2:0] == MODE_SERVER) &&
                    (item.stratum != 8'd0);

  always_comb begin
    status_nxt    = status_r;
    quick_nxt     = quick_r;
    retry_cnt_nxt = retry_cnt_r;
    tmo_cnt_nxt   = tmo_cnt_r;
    sock_nxt      = sock_r;
    result        = '0;

    unique case (item.opcode)
      OP_POLL: begin
        if (!item.link_ready && status_r != ST_SUCCESS) begin
          status_nxt = ST_INIT;
        end else begin
          case (status_r)
            ST_INIT: begin
              quick_nxt  = 4'd0;
              sock_nxt   = sock_r | item.socket_ok;
              status_nxt = sock_nxt ? ST_LOOKUP : ST_ERROR;
            end
            ST_LOOKUP: begin
              result.start_lookup = 1'b1;
              tmo_cnt_nxt = timer_load(cfg.reply_timeout_ticks);
              status_nxt  = item.lookup_immediate ? ST_REQUEST : ST_LOOKUP_WAIT;
            end
            ST_REQUEST: begin
              result.send_request = 1'b1;
              tmo_cnt_nxt = timer_load(cfg.reply_timeout_ticks);
              status_nxt  = ST_WAIT;
            end
            ST_LOOKUP_WAIT, ST_WAIT: begin
              if (tmo_cnt_r == '0) begin
                quick_nxt     = arm_quick;
                retry_cnt_nxt = arm_retry;
                status_nxt    = ST_TIMEOUT;
              end
            end
            ST_SUCCESS, ST_LOOKUP_FAIL, ST_TIMEOUT, ST_SET_FAIL: begin
              if (retry_cnt_r == '0) begin
                status_nxt = ST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        // Both countdowns saturate at zero.
        if (retry_cnt_r != '0) retry_cnt_nxt = retry_cnt_r - 1'b1;
        if (tmo_cnt_r != '0)   tmo_cnt_nxt   = tmo_cnt_r - 1'b1;
      end
      OP_LOOKUP: begin
        if (status_r == ST_LOOKUP_WAIT) begin
          if (item.lookup_found) begin
            status_nxt = ST_REQUEST;
          end else begin
            quick_nxt     = arm_quick;
            retry_cnt_nxt = arm_retry;
            status_nxt    = ST_LOOKUP_FAIL;
          end
        end
      end
      OP_REPLY: begin
        if (reply_ok) begin
          result.time_strobe  = 1'b1;
          result.unix_seconds = item.server_seconds - EPOCH_OFFSET;
          if (item.set_time_ok) begin
            retry_cnt_nxt = timer_load(cfg.refresh_ticks);
            status_nxt    = ST_SUCCESS;
          end else begin
            quick_nxt     = arm_quick;
            retry_cnt_nxt = arm_retry;
            status_nxt    = ST_SET_FAIL;
          end
        end
      end
      default: ;
    endcase

    result.status      = status_nxt;
    result.retry_count = quick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_INIT;
      quick_r     <= 4'd0;
      retry_cnt_r <= '0;
      tmo_cnt_r   <= '0;
      sock_r      <= 1'b0;
    end else if (step) begin
      status_r    <= status_nxt;
      quick_r     <= quick_nxt;
      retry_cnt_r <= retry_cnt_nxt;
      tmo_cnt_r   <= tmo_cnt_nxt;
      sock_r      <= sock_nxt;
    end
  end

endmodule

[sv/time_sync_client_sequencer.sv]
// Top level of the time sync client sequencer: handshake stages around the core.
//
// Events arrive on the in_ channel (valid/ready), one transfer per event, and
// each event yields exactly one result transfer on the out_ channel. An event
// is captured in an input register; when it is processed the sequencer state
// is updated and the result is written into the output register, from which
// it is offered. One event per cycle is sustained while the receiver takes
// results: the input and output registers each hold one item, and the
// state update plus result logic is a single pass of combinational logic.
// When the receiver stalls, the output register holds its result and the
// input register keeps the next event; in_ready drops only when both are
// full. Configuration registers are written on the cfg_ channel, which is
// always ready; write only while no event is in flight. A synchronous
// active-low reset returns the sequencer to init with zero retries and
// countdowns, empties both stages and restores the register defaults.
// TIMER_WIDTH sets the countdown width; loaded delays saturate at its top.
module time_sync_client_sequencer
  import tscs_pkg::*;
#(
  parameter int TIMER_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_data_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_data_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_regs_t cfg_regs;
  in_data_t  in_hold_r;
  logic      in_vld_r;
  out_data_t out_hold_r;
  logic      out_vld_r;
  out_data_t core_result;
  logic      step;

  assign cfg_ready = 1'b1;

  tscs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg_regs)
  );

  // The held event is processed when the output register is free or draining.
  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;

  tscs_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_hold_r),
    .cfg    (cfg_regs),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_hold_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_hold_r <= core_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_hold_r;

endmodule

[tb/tscs_checker.sv]
// Checker for the time sync client sequencer: predicts each event's report and compares.
`timescale 1ns / 1ps

module tscs_checker
  import tscs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_data_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_data_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  awaiting,
  output int                  time_updates,
  output int                  states_reached
);

  localparam int DelayW = 32;

  cfg_regs_t   regs;
  status_t     seq_state;
  logic [3:0]  quick_retries;
  logic [31:0] retry_left;
  logic [31:0] timeout_left;
  logic        socket_up;
  logic [15:0] states_hit;
  out_data_t   expected_reports[$];

  function automatic logic [31:0] clamp_delay(logic [31:0] ticks);
    logic [31:0] top;
    top = (DelayW >= 32) ? 32'hFFFF_FFFF : (32'h1 << DelayW) - 32'h1;
    return (ticks > top) ? top : ticks;
  endfunction

  function automatic void arm_retry();
    if (quick_retries < regs.retry_limit) begin
      quick_retries = quick_retries + 4'd1;
      retry_left = clamp_delay(regs.short_retry_ticks);
    end else begin
      retry_left = clamp_delay(regs.long_retry_ticks);
    end
  endfunction

  function automatic out_data_t advance_sequencer(in_data_t ev);
    out_data_t rep;
    logic      good_reply;
    rep = '0;
    case (ev.opcode)
      OP_POLL: begin
        if (!ev.link_ready && seq_state != ST_SUCCESS) begin
          seq_state = ST_INIT;
        end else begin
          case (seq_state)
            ST_INIT: begin
              quick_retries = 4'd0;
              if (!socket_up) socket_up = ev.socket_ok;
              seq_state = socket_up ? ST_LOOKUP : ST_ERROR;
            end
            ST_LOOKUP: begin
              rep.start_lookup = 1'b1;
              timeout_left = clamp_delay(regs.reply_timeout_ticks);
              seq_state = ev.lookup_immediate ? ST_REQUEST : ST_LOOKUP_WAIT;
            end
            ST_REQUEST: begin
              rep.send_request = 1'b1;
              timeout_left = clamp_delay(regs.reply_timeout_ticks);
              seq_state = ST_WAIT;
            end
            ST_LOOKUP_WAIT, ST_WAIT: begin
              if (timeout_left == 32'd0) begin
                arm_retry();
                seq_state = ST_TIMEOUT;
              end
            end
            ST_SUCCESS, ST_LOOKUP_FAIL, ST_TIMEOUT, ST_SET_FAIL: begin
              if (retry_left == 32'd0) seq_state = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (retry_left != 32'd0) retry_left = retry_left - 32'd1;
        if (timeout_left != 32'd0) timeout_left = timeout_left - 32'd1;
      end
      OP_LOOKUP: begin
        // Answers that arrive outside lookup wait are stale and dropped.
        if (seq_state == ST_LOOKUP_WAIT) begin
          if (ev.lookup_found) begin
            seq_state = ST_REQUEST;
          end else begin
            arm_retry();
            seq_state = ST_LOOKUP_FAIL;
          end
        end
      end
      default: begin
        good_reply = socket_up && ev.from_server && ev.source_port == SERVER_PORT &&
                     ev.datagram_length == MSG_LEN && ev.first_byte[2:0] == MODE_SERVER &&
                     ev.stratum != 8'd0;
        if (good_reply) begin
          rep.time_strobe = 1'b1;
          rep.unix_seconds = ev.server_seconds - EPOCH_OFFSET;
          if (ev.set_time_ok) begin
            retry_left = clamp_delay(regs.refresh_ticks);
            seq_state = ST_SUCCESS;
          end else begin
            arm_retry();
            seq_state = ST_SET_FAIL;
          end
        end
      end
    endcase
    rep.status = seq_state;
    rep.retry_count = quick_retries;
    return rep;
  endfunction

  always @(posedge clk) begin
    out_data_t want;
    out_data_t got;
    if (!rst_n) begin
      regs = '{4'd5, 32'd2000, 32'd60000, 32'd86400000, 32'd2000};
      seq_state = ST_INIT;
      quick_retries = 4'd0;
      retry_left = 32'd0;
      timeout_left = 32'd0;
      socket_up = 1'b0;
      states_hit = '0;
      expected_reports.delete();
      mismatches = 0;
      time_updates = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report with none expected: expected nothing, actual %h", $time, got);
        end else begin
          want = expected_reports.pop_front();
          if (want != got) mismatches++;
          if (want.status != got.status)
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
          if (want.start_lookup != got.start_lookup)
            $display("%0t: start_lookup mismatch: expected %0b, actual %0b",
                     $time, want.start_lookup, got.start_lookup);
          if (want.send_request != got.send_request)
            $display("%0t: send_request mismatch: expected %0b, actual %0b",
                     $time, want.send_request, got.send_request);
          if (want.time_strobe != got.time_strobe)
            $display("%0t: time_strobe mismatch: expected %0b, actual %0b",
                     $time, want.time_strobe, got.time_strobe);
          if (want.unix_seconds != got.unix_seconds)
            $display("%0t: unix_seconds mismatch: expected %h, actual %h",
                     $time, want.unix_seconds, got.unix_seconds);
          if (want.retry_count != got.retry_count)
            $display("%0t: retry_count mismatch: expected %0d, actual %0d",
                     $time, want.retry_count, got.retry_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RETRY_LIMIT:   regs.retry_limit = cfg_data[3:0];
          CFG_SHORT_RETRY:   regs.short_retry_ticks = cfg_data;
          CFG_LONG_RETRY:    regs.long_retry_ticks = cfg_data;
          CFG_REFRESH:       regs.refresh_ticks = cfg_data;
          CFG_REPLY_TIMEOUT: regs.reply_timeout_ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = advance_sequencer(in_data);
        expected_reports.push_back(want);
        states_hit[want.status] = 1'b1;
        if (want.time_strobe) time_updates++;
      end
    end
    awaiting = expected_reports.size();
    states_reached = $countones(states_hit);
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the time sync client sequencer: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tscs_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 60;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_data_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_data_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int mismatches;
  int awaiting;
  int time_updates;
  int states_reached;
  int cycles;
  int events_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;

  time_sync_client_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tscs_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .awaiting       (awaiting),
    .time_updates   (time_updates),
    .states_reached (states_reached)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // An event with a link-up poll view and a well-formed reply view.
  function automatic in_data_t base_event(logic [1:0] op);
    in_data_t ev;
    ev = '0;
    ev.opcode = op;
    ev.link_ready = 1'b1;
    ev.socket_ok = 1'b1;
    ev.lookup_found = 1'b1;
    ev.from_server = 1'b1;
    ev.source_port = SERVER_PORT;
    ev.datagram_length = MSG_LEN;
    ev.first_byte = {5'b00100, MODE_SERVER};
    ev.stratum = 8'd1;
    ev.server_seconds = EPOCH_OFFSET + 32'd1000;
    ev.set_time_ok = 1'b1;
    return ev;
  endfunction

  function automatic in_data_t random_event();
    in_data_t ev;
    int       pick;
    int       shape;
    pick = $urandom_range(0, 99);
    if (pick < 42) ev = base_event(OP_POLL);
    else if (pick < 74) ev = base_event(OP_TICK);
    else if (pick < 86) ev = base_event(OP_LOOKUP);
    else ev = base_event(OP_REPLY);
    ev.link_ready = ($urandom_range(0, 99) < 93);
    ev.socket_ok = ($urandom_range(0, 99) < 85);
    ev.lookup_immediate = 1'($urandom_range(0, 1));
    ev.lookup_found = ($urandom_range(0, 99) < 70);
    ev.first_byte = {5'($urandom_range(0, 31)), MODE_SERVER};
    ev.stratum = 8'($urandom_range(1, 255));
    ev.server_seconds = $urandom();
    ev.set_time_ok = ($urandom_range(0, 99) < 70);
    shape = $urandom_range(0, 99);
    if (shape >= 90) begin
      // Pure noise in every reply field.
      ev.from_server = 1'($urandom_range(0, 1));
      ev.source_port = 16'($urandom_range(0, 65535));
      ev.datagram_length = 16'($urandom_range(0, 65535));
      ev.first_byte = 8'($urandom_range(0, 255));
      ev.stratum = 8'($urandom_range(0, 255));
    end else if (shape >= 75) begin
      // One reply check broken, the rest well formed.
      case ($urandom_range(0, 4))
        0: ev.from_server = 1'b0;
        1: ev.source_port = 16'($urandom_range(0, 65535));
        2: ev.datagram_length = 16'($urandom_range(0, 65535));
        3: ev.first_byte[2:0] = 3'($urandom_range(0, 7));
        default: ev.stratum = 8'd0;
      endcase
    end
    return ev;
  endfunction

  task automatic send_event(in_data_t ev);
    if (events_sent < 475) begin
      tx_idle_pct = 8;
      rx_idle_pct = 65;
    end else if (events_sent < 950) begin
      tx_idle_pct = 65;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only once every report of the previous phase has come out.
  task automatic run_phase(cfg_regs_t regs, int count, int hold_at);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    write_reg(CFG_RETRY_LIMIT, CfgDataW'(regs.retry_limit));
    write_reg(CFG_SHORT_RETRY, regs.short_retry_ticks);
    write_reg(CFG_LONG_RETRY, regs.long_retry_ticks);
    write_reg(CFG_REFRESH, regs.refresh_ticks);
    write_reg(CFG_REPLY_TIMEOUT, regs.reply_timeout_ticks);
    cfg_valid <= 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_event(random_event());
    end
  endtask

  initial begin
    in_data_t  ev;
    cfg_regs_t mixed;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RETRY_LIMIT;
    cfg_data = '0;
    cycles = 0;
    events_sent = 0;
    tx_idle_pct = 8;
    rx_idle_pct = 65;
    hold_req = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through the state machine under the reset register values.
    ev = base_event(OP_REPLY);
    ev.server_seconds = EPOCH_OFFSET;
    send_event(ev);                         // reply before any endpoint exists
    send_event(base_event(OP_LOOKUP));      // stale lookup answer in init
    send_event(base_event(OP_TICK));
    ev = base_event(OP_POLL);
    ev.link_ready = 1'b0;
    send_event(ev);
    ev = base_event(OP_POLL);
    ev.socket_ok = 1'b0;
    send_event(ev);                         // no endpoint: error
    send_event(ev);                         // error holds while the link is up
    ev.link_ready = 1'b0;
    send_event(ev);                         // link down clears error
    send_event(base_event(OP_POLL));        // endpoint made
    send_event(base_event(OP_POLL));        // lookup issued, now waiting
    ev = base_event(OP_LOOKUP);
    ev.lookup_found = 1'b0;
    send_event(ev);                         // failed lookup arms a quick retry
    send_event(ev);                         // stale answer in lookup fail
    ev = base_event(OP_POLL);
    ev.link_ready = 1'b0;
    send_event(ev);
    ev = base_event(OP_POLL);
    ev.socket_ok = 1'b0;
    send_event(ev);                         // endpoint already there
    ev.lookup_immediate = 1'b1;
    send_event(ev);                         // address known at once
    send_event(base_event(OP_POLL));        // request sent
    ev = base_event(OP_REPLY);
    ev.from_server = 1'b0;
    send_event(ev);
    ev = base_event(OP_REPLY);
    ev.source_port = 16'hFFFF;
    send_event(ev);
    ev = base_event(OP_REPLY);
    ev.datagram_length = 16'hFFFF;
    send_event(ev);
    ev = base_event(OP_REPLY);
    ev.first_byte = 8'hFB;
    send_event(ev);
    ev = base_event(OP_REPLY);
    ev.stratum = 8'd0;
    send_event(ev);
    ev = base_event(OP_REPLY);
    ev.server_seconds = 32'd0;
    send_event(ev);                         // valid reply, seconds wrap below the epoch
    ev = base_event(OP_POLL);
    ev.link_ready = 1'b0;
    send_event(ev);                         // link down does not leave success
    ev = base_event(OP_REPLY);
    ev.first_byte = 8'hFC;
    ev.stratum = 8'hFF;
    ev.server_seconds = 32'hFFFF_FFFF;
    ev.set_time_ok = 1'b0;
    send_event(ev);                         // clock refuses the time
    send_event(base_event(OP_POLL));        // retry delay still running
    send_event(base_event(OP_TICK));

    run_phase('{4'd3, 32'd2, 32'd5, 32'd3, 32'd2}, 260, 120);
    run_phase('{4'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 260, -1);
    run_phase('{4'd15, 32'd1, 32'd3, 32'd1, 32'd1}, 260, -1);
    run_phase('{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 100, -1);
    mixed = '{4'($urandom_range(0, 15)), 32'($urandom_range(0, 8)), 32'($urandom_range(0, 8)),
              32'($urandom_range(0, 8)), 32'($urandom_range(0, 8))};
    run_phase(mixed, 260, 50);
    run_phase('{4'd1, 32'd4, 32'd2, 32'd2, 32'd3}, 260, -1);

    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Run covered %0d events over seven register settings in %0d cycles,",
             events_sent, cycles);
    $display("with %0d time updates and %0d of 10 sequencer states reached.",
             time_updates, states_reached);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tscs_pkg.sv
sv/tscs_cfg.sv
sv/tscs_core.sv
sv/time_sync_client_sequencer.sv
tb/tscs_checker.sv
tb/tb_top.sv
